FILE: rtl/tleb_pkg.sv
// ----------------------------------------------------------------------------
// tleb_pkg
// shared types, constants and pointer helpers for the line-edit buffer
// ----------------------------------------------------------------------------
package tleb_pkg;

    localparam int BUF_DEPTH  = 64;
    localparam int PTR_W      = $clog2(BUF_DEPTH);
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int CHAR_W     = 7;
    localparam int KIND_W     = 2;
    localparam int TAB_SPACES = 4;
    localparam int TAB_W      = $clog2(TAB_SPACES);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [TAB_W-1:0]  tab_t;

    localparam kind_t KIND_ECHO  = 2'd0;
    localparam kind_t KIND_ERASE = 2'd1;
    localparam kind_t KIND_LINE  = 2'd2;
    localparam kind_t KIND_NONE  = 2'd3;

    localparam char_t CODE_BS    = 7'd8;
    localparam char_t CODE_TAB   = 7'd9;
    localparam char_t CODE_NL    = 7'd10;
    localparam char_t CODE_CR    = 7'd13;
    localparam char_t CODE_SPACE = 7'd32;
    localparam char_t PRINT_LOW  = 7'd32;
    localparam char_t PRINT_HIGH = 7'd126;

    localparam cnt_t DEPTH_CNT   = CNT_W'(BUF_DEPTH);
    localparam cnt_t PRINT_LIMIT = CNT_W'(BUF_DEPTH - 1);
    localparam cnt_t TAB_LIMIT   = CNT_W'(BUF_DEPTH - TAB_SPACES);
    localparam tab_t TAB_LAST    = TAB_W'(TAB_SPACES - 1);
    localparam ptr_t PTR_LAST    = PTR_W'(BUF_DEPTH - 1);

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic push;
        logic rd_en;
        logic rd_tail;
        logic bs_pop;
        logic ln_pop;
        logic emit_none;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cmd_read;
        logic push_ok;
        logic bs_ok;
        logic nl_any;
        logic push_last;
        logic rd_is_nl;
        logic out_free;
        logic fill_ok;
        logic nl_ok;
    } status_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

endpackage

FILE: rtl/terminal_line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// terminal_line_edit_buffer_unit
// line-edit ring buffer for terminal keys with echo and line read results
// ----------------------------------------------------------------------------
//   channel  dir  handshake           payload
//   s_       in   s_valid / s_ready   s_cmd, s_key_char
//   m_       out  m_valid / m_ready   m_kind, m_char_out, m_last
//
// keystroke: latched, then decoded, then one echo per cycle while m_ is free (tab gives four)
// backspace: decode, then the registered ring read of the newest slot, then the erase
// line read: each delivered character is a registered ring read, then its emit,
// so the next is read only after the previous is emitted; no line ready gives a NONE result
// aresetn clears pointers, counts and the result valid flag; ring contents
// and result payload are not; a stalled m_ stage holds the sequencer at the next result
// ----------------------------------------------------------------------------
module terminal_line_edit_buffer_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_cmd,
    input  tleb_pkg::char_t s_key_char,
    output logic            m_valid,
    input  logic            m_ready,
    output tleb_pkg::kind_t m_kind,
    output tleb_pkg::char_t m_char_out,
    output logic            m_last
);
    import tleb_pkg::*;

    cmd_t    cmd;
    status_t st;

    tleb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    tleb_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_cmd      (s_cmd),
        .s_key_char (s_key_char),
        .cmd        (cmd),
        .st         (st),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_char_out (m_char_out),
        .m_last     (m_last)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while item in progress");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st.fill_ok && st.nl_ok)
        else $error("fill or newline count out of range");

    a_line_ends_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_LINE && m_last |-> m_char_out == CODE_NL)
        else $error("line closed without newline");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_NONE || m_kind == KIND_ERASE)
        |-> m_char_out == '0 && m_last)
        else $error("bad erase or no-line result");
`endif

endmodule

FILE: rtl/tleb_datapath.sv
// ----------------------------------------------------------------------------
// tleb_datapath
// character ring, pointers, newline count and the result register
// ----------------------------------------------------------------------------
module tleb_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_cmd,
    input  tleb_pkg::char_t   s_key_char,
    input  tleb_pkg::cmd_t    cmd,
    output tleb_pkg::status_t st,
    output logic              m_valid,
    input  logic              m_ready,
    output tleb_pkg::kind_t   m_kind,
    output tleb_pkg::char_t   m_char_out,
    output logic              m_last
);
    import tleb_pkg::*;

    char_t mem [BUF_DEPTH];

    logic  cmd_reg;
    char_t key_reg;
    char_t rd_data_reg;
    ptr_t  head_reg, head_next;
    ptr_t  tail_reg, tail_next;
    cnt_t  fill_reg, fill_next;
    cnt_t  nl_reg, nl_next;
    tab_t  tab_reg, tab_next;
    logic  m_valid_reg, m_valid_next;
    kind_t m_kind_reg, m_kind_next;
    char_t m_char_reg, m_char_next;
    logic  m_last_reg, m_last_next;

    logic  is_cr, is_print, is_bs, is_tab, emit;
    char_t push_char;
    ptr_t  rd_addr;

    always_comb begin
        is_cr    = (key_reg == CODE_CR);
        is_bs    = (key_reg == CODE_BS);
        is_tab   = (key_reg == CODE_TAB);
        is_print = key_reg inside {[PRINT_LOW:PRINT_HIGH]};
        push_char = is_cr ? CODE_NL : (is_tab ? CODE_SPACE : key_reg);
        rd_addr  = cmd.rd_tail ? ptr_dec(tail_reg) : head_reg;
    end

    always_comb begin
        st.cmd_read  = cmd_reg;
        st.push_ok   = (is_cr && fill_reg < DEPTH_CNT)
                     || (is_print && fill_reg < PRINT_LIMIT)
                     || (is_tab && fill_reg < TAB_LIMIT);
        st.bs_ok     = is_bs && (fill_reg != '0);
        st.nl_any    = (nl_reg != '0);
        st.push_last = !is_tab || (tab_reg == TAB_LAST);
        st.rd_is_nl  = (rd_data_reg == CODE_NL);
        st.out_free  = !m_valid_reg || m_ready;
        st.fill_ok   = (fill_reg <= DEPTH_CNT);
        st.nl_ok     = (nl_reg <= fill_reg);
    end

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        nl_next      = nl_reg;
        tab_next     = tab_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        emit         = cmd.push || cmd.bs_pop || cmd.ln_pop || cmd.emit_none;

        if (cmd.load_in) begin
            tab_next = '0;
        end
        if (cmd.push) begin
            tail_next   = ptr_inc(tail_reg);
            fill_next   = fill_reg + 1'b1;
            m_kind_next = KIND_ECHO;
            m_char_next = push_char;
            m_last_next = st.push_last;
            if (is_cr) begin
                nl_next = nl_reg + 1'b1;
            end
            if (is_tab) begin
                tab_next = tab_reg + 1'b1;
            end
        end
        if (cmd.bs_pop) begin
            tail_next   = ptr_dec(tail_reg);
            fill_next   = fill_reg - 1'b1;
            m_kind_next = KIND_ERASE;
            m_char_next = '0;
            m_last_next = 1'b1;
            if (st.rd_is_nl) begin
                nl_next = nl_reg - 1'b1;
            end
        end
        if (cmd.ln_pop) begin
            head_next   = ptr_inc(head_reg);
            fill_next   = fill_reg - 1'b1;
            m_kind_next = KIND_LINE;
            m_char_next = rd_data_reg;
            m_last_next = st.rd_is_nl;
            if (st.rd_is_nl) begin
                nl_next = nl_reg - 1'b1;
            end
        end
        if (cmd.emit_none) begin
            m_kind_next = KIND_NONE;
            m_char_next = '0;
            m_last_next = 1'b1;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            nl_reg      <= '0;
            tab_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            nl_reg      <= nl_next;
            tab_reg     <= tab_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, memory and read port
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= s_cmd;
            key_reg <= s_key_char;
        end
        if (cmd.push) begin
            mem[tail_reg] <= push_char;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        m_kind_reg <= m_kind_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_char_out = m_char_reg;
    assign m_last     = m_last_reg;

endmodule

FILE: rtl/tleb_ctrl.sv
// ----------------------------------------------------------------------------
// tleb_ctrl
// sequencer for keystroke, backspace and line read handling
// ----------------------------------------------------------------------------
module tleb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tleb_pkg::status_t st,
    output tleb_pkg::cmd_t    cmd
);
    import tleb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUSH,
        ST_BS_READ,
        ST_BS_EMIT,
        ST_LN_READ,
        ST_LN_EMIT,
        ST_NONE_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (st.cmd_read) begin
                    state_next = st.nl_any ? ST_LN_READ : ST_NONE_EMIT;
                end else if (st.push_ok) begin
                    state_next = ST_PUSH;
                end else if (st.bs_ok) begin
                    state_next = ST_BS_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH: begin
                if (st.out_free) begin
                    cmd.push = 1'b1;
                    if (st.push_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BS_READ: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_tail = 1'b1;
                state_next  = ST_BS_EMIT;
            end
            ST_BS_EMIT: begin
                if (st.out_free) begin
                    cmd.bs_pop = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LN_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LN_EMIT;
            end
            ST_LN_EMIT: begin
                if (st.out_free) begin
                    cmd.ln_pop = 1'b1;
                    state_next = st.rd_is_nl ? ST_IDLE : ST_LN_READ;
                end
            end
            ST_NONE_EMIT: begin
                if (st.out_free) begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: test/tb_terminal_line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// tb_terminal_line_edit_buffer_unit
// Drives keystrokes and line reads into the line-edit buffer and checks every
// echo, erase and line result against a predictor that keeps its own copy of
// the ring, head slot and fill count. Named tests cover the empty buffer, each
// key class, the full-buffer limits, a long output stall and random lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_terminal_line_edit_buffer_unit;
    import tleb_pkg::*;

    localparam char_t KEY_DELETE     = 7'd127;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    SETTLE_CYCLES  = 20;

    typedef struct {
        kind_t kind;
        char_t ch;
        logic  last;
    } line_result_t;

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  s_cmd;
    char_t s_key_char;
    logic  m_valid;
    logic  m_ready;
    kind_t m_kind;
    char_t m_char_out;
    logic  m_last;

    // predictor state
    char_t ring [BUF_DEPTH];
    ptr_t  ring_head;
    cnt_t  ring_fill;

    line_result_t line_results [$];
    line_result_t want;

    int error_count = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;

    terminal_line_edit_buffer_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_key_char (s_key_char),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_char_out (m_char_out),
        .m_last     (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic void expect_result(input kind_t k, input char_t c, input logic fin);
        line_result_t r;
        r.kind = k;
        r.ch   = c;
        r.last = fin;
        line_results.push_back(r);
    endfunction

    function automatic void store_char(input char_t c);
        ring[ptr_t'((int'(ring_head) + int'(ring_fill)) % BUF_DEPTH)] = c;
        ring_fill++;
    endfunction

    function automatic void predict_response(input logic cmd, input char_t key);
        int   n;
        int   i;
        bit   found;
        char_t c;
        if (!cmd) begin
            if (key == CODE_CR) begin
                if (ring_fill < DEPTH_CNT) begin
                    store_char(CODE_NL);
                    expect_result(KIND_ECHO, CODE_NL, 1'b1);
                end
            end else if (key >= PRINT_LOW && key <= PRINT_HIGH) begin
                if (ring_fill < PRINT_LIMIT) begin
                    store_char(key);
                    expect_result(KIND_ECHO, key, 1'b1);
                end
            end else if (key == CODE_BS) begin
                if (ring_fill != 0) begin
                    ring_fill--;
                    expect_result(KIND_ERASE, '0, 1'b1);
                end
            end else if (key == CODE_TAB) begin
                if (ring_fill < TAB_LIMIT) begin
                    for (i = 0; i < TAB_SPACES; i++) begin
                        store_char(CODE_SPACE);
                        expect_result(KIND_ECHO, CODE_SPACE, i == TAB_SPACES - 1);
                    end
                end
            end
        end else begin
            n = 0;
            found = 1'b0;
            for (i = 0; i < int'(ring_fill) && !found; i++) begin
                if (ring[ptr_t'((int'(ring_head) + i) % BUF_DEPTH)] == CODE_NL) begin
                    found = 1'b1;
                    n = i + 1;
                end
            end
            if (found) begin
                for (i = 0; i < n; i++) begin
                    c = ring[ptr_t'((int'(ring_head) + i) % BUF_DEPTH)];
                    expect_result(KIND_LINE, c, i == n - 1);
                end
                ring_head = ptr_t'((int'(ring_head) + n) % BUF_DEPTH);
                ring_fill = ring_fill - cnt_t'(n);
            end else begin
                expect_result(KIND_NONE, '0, 1'b1);
            end
        end
    endfunction

    function automatic char_t random_printable();
        return char_t'($urandom_range(int'(PRINT_LOW), int'(PRINT_HIGH)));
    endfunction

    task automatic send_item(input logic cmd, input char_t key);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_key_char <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        predict_response(cmd, key);
    endtask

    task automatic type_key(input char_t key);
        send_item(1'b0, key);
    endtask

    task automatic read_line();
        send_item(1'b1, char_t'($urandom_range(0, 127)));
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (line_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver side: random stalls, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (line_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d char %0d last %0d",
                                          m_kind, m_char_out, m_last));
            end else begin
                want = line_results.pop_front();
                if (m_kind !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, expected %0d", m_kind, want.kind));
                end
                if (m_char_out !== want.ch) begin
                    report_mismatch($sformatf("char_out %0d, expected %0d",
                                              m_char_out, want.ch));
                end
                if (m_last !== want.last) begin
                    report_mismatch($sformatf("last %0d, expected %0d", m_last, want.last));
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[terminal_line_edit_buffer_unit] ERROR");
            $finish;
        end
    end

    task automatic test_empty_buffer();
        read_line();
        type_key(CODE_BS);
        type_key(KEY_DELETE);
        type_key(7'd0);
        type_key(7'd31);
        wait_drain();
    endtask

    task automatic test_edit_keys();
        type_key(PRINT_LOW);
        type_key(PRINT_HIGH);
        type_key(7'h41);
        type_key(CODE_TAB);
        type_key(CODE_BS);
        type_key(KEY_DELETE);
        type_key(7'd1);
        type_key(CODE_NL);
        type_key(CODE_CR);
        send_item(1'b1, KEY_DELETE);
        send_item(1'b1, 7'd0);
        type_key(7'h78);
        type_key(CODE_CR);
        type_key(CODE_BS);
        type_key(CODE_CR);
        read_line();
        wait_drain();
    endtask

    task automatic test_full_buffer();
        int i;
        for (i = 0; i < int'(TAB_LIMIT) - 1; i++) type_key(random_printable());
        type_key(CODE_TAB);
        repeat (3) type_key(CODE_BS);
        type_key(CODE_TAB);
        repeat (3) type_key(random_printable());
        type_key(random_printable());
        type_key(CODE_TAB);
        type_key(CODE_CR);
        type_key(CODE_CR);
        type_key(random_printable());
        type_key(CODE_BS);
        type_key(CODE_CR);
        read_line();
        read_line();
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        int i;
        hold_req = 1'b1;
        for (i = 0; i < 12; i++) type_key(random_printable());
        type_key(CODE_TAB);
        type_key(CODE_CR);
        read_line();
        type_key(random_printable());
        type_key(CODE_CR);
        read_line();
        read_line();
        wait_drain();
    endtask

    task automatic send_random_traffic(input int target);
        int len;
        int i;
        int pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                len = $urandom_range(0, 12);
                for (i = 0; i < len; i++) begin
                    case ($urandom_range(0, 11))
                        0: begin
                            type_key(CODE_TAB);
                        end
                        1, 2: begin
                            type_key(CODE_BS);
                        end
                        default: begin
                            type_key(random_printable());
                        end
                    endcase
                end
                type_key(CODE_CR);
                if ($urandom_range(0, 2) != 0) read_line();
            end else if (pick == 7) begin
                read_line();
            end else begin
                send_item(1'($urandom_range(0, 1)), char_t'($urandom_range(0, 127)));
            end
        end
    endtask

    task automatic test_random_lines();
        idle_on = 1'b1;
        send_random_traffic(items_sent + 290);
        wait_drain();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_random_traffic(items_sent + 60);
        wait_drain();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_cmd      = 1'b0;
        s_key_char = '0;
        ring_head  = '0;
        ring_fill  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_buffer();
        test_edit_keys();
        test_full_buffer();
        test_output_backpressure();
        test_random_lines();
        test_steady_stream();

        if (line_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", line_results.size()));
        end
        if (error_count == 0) begin
            $display("[terminal_line_edit_buffer_unit] OK");
        end else begin
            $display("[terminal_line_edit_buffer_unit] ERROR");
        end
        $finish;
    end

endmodule
